// ===== design/sctok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer package
// Shared types, codes and character constants for the tokenizer block.
// ----------------------------------------------------------------------------
package sctok_pkg;

  // Lexer modes.
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_WORD    = 4'd1,
    M_ESC     = 4'd2,
    M_SQ      = 4'd3,
    M_DQ      = 4'd4,
    M_DQ_ESC  = 4'd5,
    M_AMP     = 4'd6,
    M_PIPE    = 4'd7,
    M_GT      = 4'd8,
    M_COMMENT = 4'd9
  } lexer_mode_t;

  // Event codes.
  localparam logic [2:0] EV_BYTE = 3'd0;
  localparam logic [2:0] EV_DONE = 3'd1;
  localparam logic [2:0] EV_OP   = 3'd2;
  localparam logic [2:0] EV_END  = 3'd3;
  localparam logic [2:0] EV_ERR  = 3'd4;

  // Operator codes.
  localparam logic [2:0] OP_SEMI   = 3'd0;
  localparam logic [2:0] OP_AMP    = 3'd1;
  localparam logic [2:0] OP_AND    = 3'd2;
  localparam logic [2:0] OP_PIPE   = 3'd3;
  localparam logic [2:0] OP_OR     = 3'd4;
  localparam logic [2:0] OP_LT     = 3'd5;
  localparam logic [2:0] OP_GT     = 3'd6;
  localparam logic [2:0] OP_APPEND = 3'd7;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BSLASH   = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED = 2'd2;

  // Characters.
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Default depth of the result queue.
  localparam int RES_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] operator_code;
    logic [7:0] word_byte;
    logic [1:0] error_code;
    logic       last_of_run;
  } tok_result_t;

  // Results of one item, with the mode that it leaves behind.
  typedef struct packed {
    logic [1:0]  n;
    tok_result_t r0;
    tok_result_t r1;
    lexer_mode_t mode;
  } step_t;

  function automatic tok_result_t make_res(logic [2:0] ev, logic [2:0] op,
                                           logic [7:0] wb, logic [1:0] err);
    tok_result_t r;
    r.event_res     = ev;
    r.operator_code = op;
    r.word_byte     = wb;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic step_t push(step_t s, tok_result_t r);
    step_t o;
    o = s;
    if (s.n == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.n = s.n + 2'd1;
    return o;
  endfunction

endpackage

// ===== design/sctok_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer channels
// Input channel (text bytes) and output channel (tokens) with valid/ready.
// ----------------------------------------------------------------------------
interface sctok_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, kind, text_byte, input ready);
  modport sink (input valid, kind, text_byte, output ready);
endinterface

interface sctok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] operator_code;
  logic [7:0] word_byte;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (output valid, event_res, operator_code, word_byte, error_code,
                  last_of_run, input ready);
  modport sink (input valid, event_res, operator_code, word_byte, error_code,
                last_of_run, output ready);
endinterface

// ===== design/sctok_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer lexer
// Holds the lexer mode and works out the results of one item in one pass.
// ----------------------------------------------------------------------------
module sctok_lexer (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           kind,
  input  logic [7:0]     text_byte,
  output sctok_pkg::step_t step
);
  import sctok_pkg::*;

  lexer_mode_t mode;

  // Treats c as arriving between tokens, or as continuing a word.
  function automatic step_t start_byte(step_t s_in, logic [7:0] c, logic in_word);
    step_t s;
    logic  is_op;
    logic  is_sp;
    s     = s_in;
    is_op = (c == CH_SEMI) || (c == CH_AMP) || (c == CH_PIPE) ||
            (c == CH_LT) || (c == CH_GT);
    is_sp = (c == CH_SPACE) || (c == CH_TAB);
    if (in_word) begin
      if (is_sp || is_op) begin
        s      = push(s, make_res(EV_DONE, OP_SEMI, 8'd0, ERR_NONE));
        s.mode = M_IDLE;
        if (!is_op) begin
          return s;
        end
      end
    end else begin
      if (is_sp) begin
        return s;
      end
      if (c == CH_HASH) begin
        s.mode = M_COMMENT;
        return s;
      end
    end
    if (is_op) begin
      case (c)
        CH_SEMI: begin
          s.mode = M_IDLE;
          s      = push(s, make_res(EV_OP, OP_SEMI, 8'd0, ERR_NONE));
        end
        CH_LT: begin
          s.mode = M_IDLE;
          s      = push(s, make_res(EV_OP, OP_LT, 8'd0, ERR_NONE));
        end
        CH_AMP:  s.mode = M_AMP;
        CH_PIPE: s.mode = M_PIPE;
        default: s.mode = M_GT;
      endcase
    end else if (c == CH_BSLASH) begin
      s.mode = M_ESC;
    end else if (c == CH_SQUOTE) begin
      s.mode = M_SQ;
    end else if (c == CH_DQUOTE) begin
      s.mode = M_DQ;
    end else begin
      s.mode = M_WORD;
      s      = push(s, make_res(EV_BYTE, OP_SEMI, c, ERR_NONE));
    end
    return s;
  endfunction

  // A pending & | or > either doubles or is emitted before c is handled.
  function automatic step_t pending_op(step_t s_in, logic [7:0] c, logic [7:0] ch,
                                       logic [2:0] op_single, logic [2:0] op_double);
    step_t s;
    s      = s_in;
    s.mode = M_IDLE;
    if (c == ch) begin
      s = push(s, make_res(EV_OP, op_double, 8'd0, ERR_NONE));
    end else begin
      s = push(s, make_res(EV_OP, op_single, 8'd0, ERR_NONE));
      s = start_byte(s, c, 1'b0);
    end
    return s;
  endfunction

  step_t s0;
  step_t s;

  always_comb begin
    s0.n    = 2'd0;
    s0.r0   = make_res(EV_BYTE, OP_SEMI, 8'd0, ERR_NONE);
    s0.r1   = make_res(EV_BYTE, OP_SEMI, 8'd0, ERR_NONE);
    s0.mode = mode;
  end

  always_comb begin
    s = s0;
    if (kind) begin
      s.mode = M_IDLE;
      case (mode)
        M_WORD: begin
          s = push(s, make_res(EV_DONE, OP_SEMI, 8'd0, ERR_NONE));
          s = push(s, make_res(EV_END, OP_SEMI, 8'd0, ERR_NONE));
        end
        M_ESC: s = push(s, make_res(EV_ERR, OP_SEMI, 8'd0, ERR_BSLASH));
        M_SQ, M_DQ, M_DQ_ESC: begin
          s = push(s, make_res(EV_ERR, OP_SEMI, 8'd0, ERR_UNCLOSED));
        end
        M_AMP: begin
          s = push(s, make_res(EV_OP, OP_AMP, 8'd0, ERR_NONE));
          s = push(s, make_res(EV_END, OP_SEMI, 8'd0, ERR_NONE));
        end
        M_PIPE: begin
          s = push(s, make_res(EV_OP, OP_PIPE, 8'd0, ERR_NONE));
          s = push(s, make_res(EV_END, OP_SEMI, 8'd0, ERR_NONE));
        end
        M_GT: begin
          s = push(s, make_res(EV_OP, OP_GT, 8'd0, ERR_NONE));
          s = push(s, make_res(EV_END, OP_SEMI, 8'd0, ERR_NONE));
        end
        default: s = push(s, make_res(EV_END, OP_SEMI, 8'd0, ERR_NONE));
      endcase
    end else begin
      case (mode)
        M_WORD: s = start_byte(s, text_byte, 1'b1);
        M_ESC: begin
          s.mode = M_WORD;
          s      = push(s, make_res(EV_BYTE, OP_SEMI, text_byte, ERR_NONE));
        end
        M_SQ: begin
          if (text_byte == CH_SQUOTE) begin
            s.mode = M_WORD;
          end else begin
            s = push(s, make_res(EV_BYTE, OP_SEMI, text_byte, ERR_NONE));
          end
        end
        M_DQ: begin
          if (text_byte == CH_DQUOTE) begin
            s.mode = M_WORD;
          end else if (text_byte == CH_BSLASH) begin
            s.mode = M_DQ_ESC;
          end else begin
            s = push(s, make_res(EV_BYTE, OP_SEMI, text_byte, ERR_NONE));
          end
        end
        M_DQ_ESC: begin
          s.mode = M_DQ;
          s      = push(s, make_res(EV_BYTE, OP_SEMI, text_byte, ERR_NONE));
        end
        M_AMP:  s = pending_op(s, text_byte, CH_AMP, OP_AMP, OP_AND);
        M_PIPE: s = pending_op(s, text_byte, CH_PIPE, OP_PIPE, OP_OR);
        M_GT:   s = pending_op(s, text_byte, CH_GT, OP_GT, OP_APPEND);
        M_COMMENT: s.mode = M_COMMENT;
        default: begin
          s.mode = M_IDLE;
          s      = start_byte(s, text_byte, 1'b0);
        end
      endcase
    end
    // Mark the final result of this item.
    if (s.n == 2'd2) begin
      s.r1.last_of_run = 1'b1;
    end else if (s.n == 2'd1) begin
      s.r0.last_of_run = 1'b1;
    end
  end

  assign step = s;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
    end else if (accept) begin
      mode <= s.mode;
    end
  end

`ifndef SYNTHESIS
  a_eot_idle: assert property (@(posedge clk) disable iff (rst)
    accept && kind |=> mode == M_IDLE)
    else $error("mode not idle after end of text");

  a_comment_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !kind && mode == M_COMMENT |=> mode == M_COMMENT)
    else $error("comment left before end of text");

  a_pair_first: assert property (@(posedge clk) disable iff (rst)
    accept && step.n == 2'd2 |->
      (step.r0.event_res == EV_DONE || step.r0.event_res == EV_OP))
    else $error("first of two results is neither word done nor operator");
`endif

endmodule

// ===== design/sctok_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer result queue
// Small register queue that takes up to two results a cycle, gives one while the output is ready.
// ----------------------------------------------------------------------------
module sctok_result_fifo #(
  parameter int DEPTH = sctok_pkg::RES_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  sctok_pkg::step_t           step,
  output logic [$clog2(DEPTH+1)-1:0] count,
  sctok_out_if.source                tokens
);
  import sctok_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_result_t   mem [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_inc;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] rd_ptr_next;
  logic [CW-1:0] count_next;
  logic [1:0]    push_n;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_n     = push ? step.n : 2'd0;
  assign pop        = tokens.valid && tokens.ready;
  assign wr_ptr_inc = ptr_inc(wr_ptr);

  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_next = wr_ptr_inc;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= step.r0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_inc] <= step.r1;
    end
  end

  assign tokens.valid         = (count != '0);
  assign tokens.event_res     = mem[rd_ptr].event_res;
  assign tokens.operator_code = mem[rd_ptr].operator_code;
  assign tokens.word_byte     = mem[rd_ptr].word_byte;
  assign tokens.error_code    = mem[rd_ptr].error_code;
  assign tokens.last_of_run   = mem[rd_ptr].last_of_run;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> (CW + 1)'(count) + (CW + 1)'(push_n) <= (CW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && push_n == 2'd0 |=> count == $past(count) - 1'b1)
    else $error("result queue count did not fall on a pop");
`endif

endmodule

// ===== design/shell_command_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer unit
// Splits a command line, one byte per item, into word bytes, word-done marks,
// operators, line ends and errors.
//   Latency: the first result of an item is shown in the cycle after it is
//   accepted if the queue was empty, else after the results queued before it.
//   Throughput: one item per cycle while each item gives at most one result
//   and results are taken; an item with two results gives them out one at a time.
//   Input ready is held by the result queue, which needs two free entries.
//   Reset returns the lexer to idle between tokens and empties the queue.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_unit #(
  parameter int RES_DEPTH = sctok_pkg::RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sctok_in_if.sink    text,
  sctok_out_if.source tokens
);
  import sctok_pkg::*;

  localparam int CW = $clog2(RES_DEPTH + 1);

  step_t         step;
  logic          accept;
  logic [CW-1:0] count;

  assign text.ready = (count <= CW'(RES_DEPTH - 2));
  assign accept     = text.valid && text.ready;

  sctok_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (text.kind),
    .text_byte (text.text_byte),
    .step      (step)
  );

  sctok_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .step   (step),
    .count  (count),
    .tokens (tokens)
  );

`ifndef SYNTHESIS
  a_eot_yields: assert property (@(posedge clk) disable iff (rst)
    accept && text.kind |-> step.n != 2'd0)
    else $error("end of text gave no result");

  a_valid_after_result: assert property (@(posedge clk) disable iff (rst)
    accept && step.n != 2'd0 |=> tokens.valid)
    else $error("result not shown after accepted item");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    accept && step.n == 2'd2 |-> step.r1.last_of_run && !step.r0.last_of_run)
    else $error("last-of-run mark misplaced");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command tokenizer testbench
// Feeds command lines, one byte per item, into the tokenizer, predicts the
// token stream from a lexer model of its own and checks every result field by
// field, with random gaps on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;
  import sctok_pkg::*;

  typedef struct {
    bit         is_eot;
    logic [7:0] ch;
  } text_item_t;

  logic clk;
  logic rst;

  sctok_in_if  text_ch ();
  sctok_out_if tok_ch ();

  shell_command_tokenizer_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (tok_ch)
  );

  text_item_t  pending_text[$];
  tok_result_t exp_tokens[$];
  lexer_mode_t lex_mode = M_IDLE;
  int          mismatch_count = 0;
  bit          text_taken = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          in_odds = 0;
  int          out_odds = 0;
  int          cycle_count = 0;

  logic [7:0] specials [11] = '{CH_SEMI, CH_AMP, CH_PIPE, CH_LT, CH_GT, CH_HASH,
                                CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_SPACE, CH_TAB};

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Lexer prediction
  // --------------------------------------------------------------------------
  function automatic bit is_op_char(logic [7:0] c);
    return c == CH_SEMI || c == CH_AMP || c == CH_PIPE || c == CH_LT || c == CH_GT;
  endfunction

  task automatic add_token(logic [2:0] ev, logic [2:0] op, logic [7:0] wb,
                           logic [1:0] err);
    tok_result_t t;
    t.event_res     = ev;
    t.operator_code = op;
    t.word_byte     = wb;
    t.error_code    = err;
    t.last_of_run   = 1'b0;
    exp_tokens.push_back(t);
  endtask

  // A byte seen between tokens, or one that may continue the current word.
  task automatic lex_start(logic [7:0] c, bit in_word);
    bit blank;
    blank = c == CH_SPACE || c == CH_TAB;
    if (in_word && (blank || is_op_char(c))) begin
      add_token(EV_DONE, OP_SEMI, 8'h00, ERR_NONE);
      lex_mode = M_IDLE;
    end
    if (blank) begin
      // Separators give nothing further.
    end else if (!in_word && c == CH_HASH) begin
      lex_mode = M_COMMENT;
    end else begin
      case (c)
        CH_SEMI: begin
          lex_mode = M_IDLE;
          add_token(EV_OP, OP_SEMI, 8'h00, ERR_NONE);
        end
        CH_LT: begin
          lex_mode = M_IDLE;
          add_token(EV_OP, OP_LT, 8'h00, ERR_NONE);
        end
        CH_AMP:    lex_mode = M_AMP;
        CH_PIPE:   lex_mode = M_PIPE;
        CH_GT:     lex_mode = M_GT;
        CH_BSLASH: lex_mode = M_ESC;
        CH_SQUOTE: lex_mode = M_SQ;
        CH_DQUOTE: lex_mode = M_DQ;
        default: begin
          lex_mode = M_WORD;
          add_token(EV_BYTE, OP_SEMI, c, ERR_NONE);
        end
      endcase
    end
  endtask

  // A pending single operator either doubles or is issued before the byte.
  task automatic lex_pending(logic [7:0] c, logic [7:0] twin, logic [2:0] single,
                             logic [2:0] doubled);
    lex_mode = M_IDLE;
    if (c == twin) begin
      add_token(EV_OP, doubled, 8'h00, ERR_NONE);
    end else begin
      add_token(EV_OP, single, 8'h00, ERR_NONE);
      lex_start(c, 1'b0);
    end
  endtask

  task automatic lex_step(bit eot, logic [7:0] c);
    int          before_n;
    tok_result_t t;
    bit          failed;
    before_n = exp_tokens.size();
    failed = 1'b0;
    if (eot) begin
      case (lex_mode)
        M_WORD: add_token(EV_DONE, OP_SEMI, 8'h00, ERR_NONE);
        M_ESC: begin
          add_token(EV_ERR, OP_SEMI, 8'h00, ERR_BSLASH);
          failed = 1'b1;
        end
        M_SQ, M_DQ, M_DQ_ESC: begin
          add_token(EV_ERR, OP_SEMI, 8'h00, ERR_UNCLOSED);
          failed = 1'b1;
        end
        M_AMP:  add_token(EV_OP, OP_AMP, 8'h00, ERR_NONE);
        M_PIPE: add_token(EV_OP, OP_PIPE, 8'h00, ERR_NONE);
        M_GT:   add_token(EV_OP, OP_GT, 8'h00, ERR_NONE);
        default: ;
      endcase
      if (!failed) begin
        add_token(EV_END, OP_SEMI, 8'h00, ERR_NONE);
      end
      lex_mode = M_IDLE;
    end else begin
      case (lex_mode)
        M_WORD: lex_start(c, 1'b1);
        M_ESC: begin
          lex_mode = M_WORD;
          add_token(EV_BYTE, OP_SEMI, c, ERR_NONE);
        end
        M_SQ: begin
          if (c == CH_SQUOTE) begin
            lex_mode = M_WORD;
          end else begin
            add_token(EV_BYTE, OP_SEMI, c, ERR_NONE);
          end
        end
        M_DQ: begin
          if (c == CH_DQUOTE) begin
            lex_mode = M_WORD;
          end else if (c == CH_BSLASH) begin
            lex_mode = M_DQ_ESC;
          end else begin
            add_token(EV_BYTE, OP_SEMI, c, ERR_NONE);
          end
        end
        M_DQ_ESC: begin
          lex_mode = M_DQ;
          add_token(EV_BYTE, OP_SEMI, c, ERR_NONE);
        end
        M_AMP:     lex_pending(c, CH_AMP, OP_AMP, OP_AND);
        M_PIPE:    lex_pending(c, CH_PIPE, OP_PIPE, OP_OR);
        M_GT:      lex_pending(c, CH_GT, OP_GT, OP_APPEND);
        M_COMMENT: ;
        default: begin
          lex_mode = M_IDLE;
          lex_start(c, 1'b0);
        end
      endcase
    end
    if (exp_tokens.size() > before_n) begin
      t = exp_tokens.pop_back();
      t.last_of_run = 1'b1;
      exp_tokens.push_back(t);
    end
  endtask

  // --------------------------------------------------------------------------
  // Command line generation
  // --------------------------------------------------------------------------
  task automatic put_char(logic [7:0] c);
    text_item_t it;
    it.is_eot = 1'b0;
    it.ch     = c;
    pending_text.push_back(it);
  endtask

  task automatic put_eot();
    text_item_t it;
    it.is_eot = 1'b1;
    it.ch     = 8'($urandom_range(0, 255));
    pending_text.push_back(it);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i]);
    end
  endtask

  function automatic logic [7:0] rand_any();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic bit is_special(logic [7:0] c);
    bit hit;
    hit = 1'b0;
    foreach (specials[i]) begin
      if (specials[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    c = rand_any();
    while (is_special(c)) c = rand_any();
    return c;
  endfunction

  function automatic logic [7:0] rand_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    c = rand_any();
    while (c == a || c == b) c = rand_any();
    return c;
  endfunction

  function automatic logic [7:0] rand_mixed();
    case ($urandom_range(0, 2))
      0:       return rand_plain();
      1:       return specials[$urandom_range(0, 10)];
      default: return rand_any();
    endcase
  endfunction

  task automatic put_blank();
    put_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic gen_word();
    int parts;
    int k;
    parts = $urandom_range(1, 4);
    for (int i = 0; i < parts; i++) begin
      case ($urandom_range(0, 5))
        3: begin
          put_char(CH_BSLASH);
          put_char(rand_any());
        end
        4: begin
          put_char(CH_SQUOTE);
          k = $urandom_range(0, 4);
          for (int j = 0; j < k; j++) put_char(rand_except(CH_SQUOTE, CH_SQUOTE));
          put_char(CH_SQUOTE);
        end
        5: begin
          put_char(CH_DQUOTE);
          k = $urandom_range(0, 4);
          for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 3) == 0) begin
              put_char(CH_BSLASH);
              put_char(rand_any());
            end else begin
              put_char(rand_except(CH_DQUOTE, CH_BSLASH));
            end
          end
          put_char(CH_DQUOTE);
        end
        default: put_char(rand_plain());
      endcase
    end
  endtask

  task automatic gen_operator();
    case ($urandom_range(0, 7))
      0: put_str(";");
      1: put_str("&");
      2: put_str("&&");
      3: put_str("|");
      4: put_str("||");
      5: put_str("<");
      6: put_str(">");
      default: put_str(">>");
    endcase
  endtask

  // Mostly well-formed lines with random content; the rest end inside an
  // escape or a quote, or are plain noise.
  task automatic gen_line();
    int ntok;
    int k;
    bit prev_word;
    bit cur_word;
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 4) == 0) put_blank();
      ntok = $urandom_range(1, 8);
      prev_word = 1'b0;
      for (int t = 0; t < ntok; t++) begin
        cur_word = $urandom_range(0, 2) != 0;
        if (t > 0 && ((prev_word && cur_word) || $urandom_range(0, 1) == 1)) put_blank();
        if (cur_word) gen_word();
        else gen_operator();
        prev_word = cur_word;
      end
      if ($urandom_range(0, 6) == 0) begin
        put_blank();
        put_char(CH_HASH);
        k = $urandom_range(0, 8);
        for (int j = 0; j < k; j++) put_char(rand_mixed());
      end else if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: put_char(CH_BSLASH);
          1: begin
            put_char(CH_SQUOTE);
            put_char(rand_except(CH_SQUOTE, CH_SQUOTE));
          end
          default: begin
            put_char(CH_DQUOTE);
            if ($urandom_range(0, 1) == 1) put_char(CH_BSLASH);
          end
        endcase
      end
    end else begin
      k = $urandom_range(0, 20);
      for (int j = 0; j < k; j++) put_char(rand_mixed());
    end
    put_eot();
  endtask

  // --------------------------------------------------------------------------
  // Driver: text items launched and token ready driven at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    text_item_t it;
    bit quiet;
    if (!rst) begin
      quiet = pending_text.size() < 200;
      cycle_count++;
      if (cycle_count % 200 == 0) begin
        in_odds  = $urandom_range(0, 3);
        out_odds = $urandom_range(0, 3);
      end
      if (!text_ch.valid || text_taken) begin
        text_taken = 1'b0;
        if (in_gap > 0 && !quiet) begin
          in_gap--;
          text_ch.valid <= 1'b0;
        end else if (pending_text.size() == 0) begin
          text_ch.valid <= 1'b0;
        end else if (!quiet && in_odds != 0 && $urandom_range(1, 12) <= in_odds) begin
          in_gap = $urandom_range(0, 13);
          text_ch.valid <= 1'b0;
        end else begin
          it = pending_text.pop_front();
          text_ch.valid     <= 1'b1;
          text_ch.kind      <= it.is_eot;
          text_ch.text_byte <= it.ch;
        end
      end
      if (out_stall > 0 && !quiet) begin
        out_stall--;
        tok_ch.ready <= 1'b0;
      end else if (!quiet && out_odds != 0 && $urandom_range(1, 12) <= out_odds) begin
        out_stall = $urandom_range(0, 13);
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: tokens checked and text items predicted at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tok_result_t want;
    if (!rst) begin
      if (tok_ch.valid && tok_ch.ready) begin
        if (exp_tokens.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected token ev=%0d op=%0d byte=%02h err=%0d last=%0b",
                   $time, tok_ch.event_res, tok_ch.operator_code, tok_ch.word_byte,
                   tok_ch.error_code, tok_ch.last_of_run);
        end else begin
          want = exp_tokens.pop_front();
          if (tok_ch.event_res !== want.event_res
              || tok_ch.operator_code !== want.operator_code
              || tok_ch.word_byte !== want.word_byte
              || tok_ch.error_code !== want.error_code
              || tok_ch.last_of_run !== want.last_of_run) begin
            mismatch_count++;
            $display("%0t: token mismatch expected ev=%0d op=%0d byte=%02h err=%0d last=%0b",
                     $time, want.event_res, want.operator_code, want.word_byte,
                     want.error_code, want.last_of_run);
            $display("%0t:                  actual ev=%0d op=%0d byte=%02h err=%0d last=%0b",
                     $time, tok_ch.event_res, tok_ch.operator_code, tok_ch.word_byte,
                     tok_ch.error_code, tok_ch.last_of_run);
          end
        end
      end
      if (text_ch.valid && text_ch.ready) begin
        lex_step(text_ch.kind, text_ch.text_byte);
        text_taken = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    text_ch.valid     = 1'b0;
    text_ch.kind      = 1'b0;
    text_ch.text_byte = 8'h00;
    tok_ch.ready      = 1'b0;

    // Hash inside a word, top byte, pipe ending a word then a plain byte.
    put_str("a#");
    put_char(8'hFF);
    put_str("|b");
    put_eot();
    // Empty quoted word, then a redirect left pending at end of text.
    put_str("''>");
    put_eot();
    // Doubled ampersand, lowest bytes, tab separator, comment to end of text.
    put_str("&&");
    put_char(8'h01);
    put_char(8'h00);
    put_char(CH_TAB);
    put_str("#x;");
    put_eot();
    // Escape inside double quotes cut off by end of text.
    put_str("\"\\");
    put_eot();
    // Trailing backslash.
    put_str("\\");
    put_eot();
    put_str("||>>;<\\ ");
    put_eot();

    while (pending_text.size() < 1700) gen_line();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_text.size() != 0 || text_ch.valid || exp_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sctok_pkg.sv
design/sctok_if.sv
design/sctok_lexer.sv
design/sctok_result_fifo.sv
design/shell_command_tokenizer_unit.sv
sim/testbench.sv
